// File: hw/rtl/ofp_pkg.sv
// Shared types and constants of the optical-flow frame parser.
package ofp_pkg;

  // Width of the running flow sums; the ports always show 32 bits.
  localparam int SUM_WIDTH = 32;

  localparam logic [7:0] HDR0_BYTE = 8'hFE;
  localparam logic [7:0] HDR1_BYTE = 8'h04;
  localparam logic [7:0] TAIL_BYTE = 8'hAA;

  localparam logic [7:0] QUALITY_THRESHOLD_RESET = 8'd25;
  localparam logic [7:0] FAULT_LIMIT_RESET       = 8'd60;

  // Last byte position of each frame format (length minus one).
  localparam logic [3:0] LAST_IDX_SHORT = 4'd8;
  localparam logic [3:0] LAST_IDX_LONG  = 4'd10;
  // Frame store holds byte positions FIRST_STORED .. FIRST_STORED + 7.
  localparam logic [3:0] FIRST_STORED   = 4'd2;
  localparam logic [3:0] LAST_STORED    = 4'd9;

  // Command codes.
  localparam logic CMD_BYTE  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  // Configuration register indexes.
  localparam logic [1:0] REG_FRAME_FORMAT      = 2'd0;
  localparam logic [1:0] REG_QUALITY_THRESHOLD = 2'd1;
  localparam logic [1:0] REG_FAULT_LIMIT       = 2'd2;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } ofp_in_t;

  typedef struct packed {
    logic               frame_done;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic        [7:0]  quality;
    logic signed [15:0] height;
    logic signed [31:0] sum_x;
    logic signed [31:0] sum_y;
    logic signed [31:0] total_x;
    logic signed [31:0] total_y;
    logic               flow_valid;
    logic        [15:0] frame_count;
  } ofp_out_t;

  typedef struct packed {
    logic       frame_format;
    logic [7:0] quality_threshold;
    logic [7:0] fault_limit;
  } ofp_cfg_t;

  // A checked frame as seen by the accumulator.
  typedef struct packed {
    logic               good;
    logic               long_fmt;
    logic signed [15:0] flow_x;
    logic signed [15:0] flow_y;
    logic        [7:0]  quality;
    logic signed [15:0] height;
  } ofp_frame_t;

endpackage

// File: hw/rtl/ofp_parser.sv
// Header hunt, frame collection and tail/checksum check.
module ofp_parser import ofp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  ofp_in_t    item,
  input  logic       frame_format,
  output ofp_frame_t frame
);

  typedef enum logic [2:0] {
    PH_HUNT = 3'b001,
    PH_HDR  = 3'b010,
    PH_BODY = 3'b100
  } phase_t;

  phase_t     phase, phase_next;
  logic [3:0] byte_index, byte_index_next;
  logic [7:0] store [8];

  logic [3:0] last_idx;
  logic [3:0] store_off;
  logic       store_we;
  logic       at_end;
  logic [7:0] ck_short, ck_long;
  logic       ck_ok;
  logic [7:0] qual;

  assign last_idx  = frame_format ? LAST_IDX_LONG : LAST_IDX_SHORT;
  assign store_off = byte_index - FIRST_STORED;
  assign at_end    = (byte_index >= last_idx);

  always_comb begin
    phase_next      = phase;
    byte_index_next = byte_index;
    store_we        = 1'b0;
    if (item.command == CMD_BYTE) begin
      unique case (phase)
        PH_HUNT: begin
          if (item.rx_byte == HDR0_BYTE) begin
            phase_next      = PH_HDR;
            byte_index_next = 4'd1;
          end else begin
            byte_index_next = 4'd0;
          end
        end
        PH_HDR: begin
          if (item.rx_byte == HDR1_BYTE) begin
            phase_next      = PH_BODY;
            byte_index_next = FIRST_STORED;
          end else begin
            phase_next      = PH_HUNT;
            byte_index_next = 4'd0;
          end
        end
        PH_BODY: begin
          store_we = (byte_index <= LAST_STORED);
          if (at_end) begin
            phase_next      = PH_HUNT;
            byte_index_next = 4'd0;
          end else begin
            byte_index_next = byte_index + 4'd1;
          end
        end
        default: begin
          phase_next      = PH_HUNT;
          byte_index_next = 4'd0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HUNT;
      byte_index <= 4'd0;
    end else if (fire) begin
      phase      <= phase_next;
      byte_index <= byte_index_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && store_we) begin
      store[store_off[2:0]] <= item.rx_byte;
    end
  end

  // Checksum and quality come from stored bytes; the tail is the live byte.
  assign ck_short = store[0] + store[1] + store[2] + store[3];
  assign ck_long  = ck_short + store[4] + store[5];
  assign ck_ok    = frame_format ? (ck_long == store[6]) : (ck_short == store[4]);
  assign qual     = frame_format ? store[7] : store[5];

  always_comb begin
    frame.good     = (item.command == CMD_BYTE) && (phase == PH_BODY) && at_end &&
                     (item.rx_byte == TAIL_BYTE) && ck_ok;
    frame.long_fmt = frame_format;
    frame.flow_x   = {store[1], store[0]};
    frame.flow_y   = {store[3], store[2]};
    frame.height   = {store[5], store[4]};
    frame.quality  = qual;
  end

endmodule

// File: hw/rtl/ofp_accum.sv
// Latched frame values, running sums, frame count and quality fault tracking.
module ofp_accum import ofp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic       clear,
  input  ofp_frame_t frame,
  input  ofp_cfg_t   cfg,
  output ofp_out_t   result
);

  logic signed [15:0]    flow_x, flow_x_next;
  logic signed [15:0]    flow_y, flow_y_next;
  logic        [7:0]     quality, quality_next;
  logic signed [15:0]    height, height_next;
  logic [SUM_WIDTH-1:0]  sum_x, sum_x_next;
  logic [SUM_WIDTH-1:0]  sum_y, sum_y_next;
  logic [SUM_WIDTH-1:0]  total_x, total_x_next;
  logic [SUM_WIDTH-1:0]  total_y, total_y_next;
  logic [15:0]           frame_count, frame_count_next;
  logic [7:0]            fault_count, fault_count_next;
  logic                  flow_valid, flow_valid_next;
  logic [8:0]            fault_inc;

  // Sign-extend or truncate a running sum to the 32-bit port view.
  function automatic logic signed [31:0] sum_view(input logic [SUM_WIDTH-1:0] s);
    logic signed [63:0] w;
    w = 64'(signed'(s));
    return w[31:0];
  endfunction

  assign fault_inc = {1'b0, fault_count} + 9'd1;

  always_comb begin
    flow_x_next      = flow_x;
    flow_y_next      = flow_y;
    quality_next     = quality;
    height_next      = height;
    sum_x_next       = sum_x;
    sum_y_next       = sum_y;
    total_x_next     = total_x;
    total_y_next     = total_y;
    frame_count_next = frame_count;
    fault_count_next = fault_count;
    flow_valid_next  = flow_valid;
    if (clear) begin
      sum_x_next = '0;
      sum_y_next = '0;
    end else if (frame.good) begin
      flow_x_next      = frame.flow_x;
      flow_y_next      = frame.flow_y;
      quality_next     = frame.quality;
      sum_x_next       = sum_x + SUM_WIDTH'(frame.flow_x);
      sum_y_next       = sum_y + SUM_WIDTH'(frame.flow_y);
      frame_count_next = frame_count + 16'd1;
      if (frame.long_fmt) begin
        height_next  = frame.height;
        total_x_next = total_x + SUM_WIDTH'(frame.flow_x);
        total_y_next = total_y + SUM_WIDTH'(frame.flow_y);
      end
      if (frame.quality < cfg.quality_threshold) begin
        if (fault_inc > {1'b0, cfg.fault_limit}) begin
          fault_count_next = cfg.fault_limit;
          flow_valid_next  = 1'b0;
        end else begin
          fault_count_next = fault_inc[7:0];
        end
      end else begin
        fault_count_next = 8'd0;
        flow_valid_next  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_x      <= '0;
      flow_y      <= '0;
      quality     <= '0;
      height      <= '0;
      sum_x       <= '0;
      sum_y       <= '0;
      total_x     <= '0;
      total_y     <= '0;
      frame_count <= '0;
      fault_count <= '0;
      flow_valid  <= 1'b0;
    end else if (fire) begin
      flow_x      <= flow_x_next;
      flow_y      <= flow_y_next;
      quality     <= quality_next;
      height      <= height_next;
      sum_x       <= sum_x_next;
      sum_y       <= sum_y_next;
      total_x     <= total_x_next;
      total_y     <= total_y_next;
      frame_count <= frame_count_next;
      fault_count <= fault_count_next;
      flow_valid  <= flow_valid_next;
    end
  end

  always_comb begin
    result.frame_done  = frame.good && !clear;
    result.flow_x      = flow_x_next;
    result.flow_y      = flow_y_next;
    result.quality     = quality_next;
    result.height      = height_next;
    result.sum_x       = sum_view(sum_x_next);
    result.sum_y       = sum_view(sum_y_next);
    result.total_x     = sum_view(total_x_next);
    result.total_y     = sum_view(total_y_next);
    result.flow_valid  = flow_valid_next;
    result.frame_count = frame_count_next;
  end

endmodule

// File: hw/rtl/optical_flow_frame_parser.sv
// Optical-flow sensor frame parser: top level with input and result registers.
// Path: a byte beat is held in the input register, then its result beat in the result register.
// Throughput: one beat per cycle; the input register advances whenever the
//   result register is empty or its beat is taken in the same cycle.
// Reset (rst, synchronous): both registers empty, parser hunting for a header,
//   all latched values, sums and counters zero, registers at their defaults.
module optical_flow_frame_parser import ofp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  // received byte / clear command channel
  input  logic       rx_valid,
  output logic       rx_stall,
  input  ofp_in_t    rx_item,
  // result channel, one beat per input beat
  output logic       res_valid,
  input  logic       res_stall,
  output ofp_out_t   res_item,
  // configuration write channel
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  ofp_cfg_t   cfg;
  logic       stage_valid;
  ofp_in_t    stage_item;
  logic       advance;
  logic       fire;
  ofp_frame_t frame;
  ofp_out_t   result;

  // Configuration: always ready; writes to an unused index are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_format      <= 1'b1;
      cfg.quality_threshold <= QUALITY_THRESHOLD_RESET;
      cfg.fault_limit       <= FAULT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_FRAME_FORMAT:      cfg.frame_format      <= cfg_data[0];
        REG_QUALITY_THRESHOLD: cfg.quality_threshold <= cfg_data;
        REG_FAULT_LIMIT:       cfg.fault_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  // The staged beat moves into the result register when that register is
  // free this cycle. The staged beat is processed exactly on that move.
  assign advance  = !res_valid || !res_stall;
  assign fire     = stage_valid && advance;
  assign rx_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!rx_stall) begin
      stage_valid <= rx_valid;
    end
  end

  // Hold the staged payload while stalled.
  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      stage_item <= rx_item;
    end
  end

  ofp_parser u_parser (
    .clk          (clk),
    .rst          (rst),
    .fire         (fire),
    .item         (stage_item),
    .frame_format (cfg.frame_format),
    .frame        (frame)
  );

  ofp_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .clear  (stage_item.command == CMD_CLEAR),
    .frame  (frame),
    .cfg    (cfg),
    .result (result)
  );

  // Result register: load on fire, drop valid once taken with nothing behind.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_item <= result;
    end
  end

endmodule

// File: hw/rtl/ofp_checker.sv
// Port-level checker for the optical-flow frame parser, bound to the top level.
module ofp_checker import ofp_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       rx_valid,
  input logic       rx_stall,
  input logic       res_valid,
  input logic       res_stall,
  input ofp_out_t   res_item
);

  // A stalled result beat holds.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res_item))
    else $error("result beat changed while stalled");

  // Reset leaves both sides empty and open.
  assert property (@(posedge clk)
    rst |=> !res_valid && !rx_stall)
    else $error("not empty after reset");

  // An empty result register never back-pressures the input.
  assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !rx_stall)
    else $error("input stalled with empty result register");

  // A beat taken while the result register is empty shows its result once it has passed both registers.
  assert property (@(posedge clk) disable iff (rst)
    rx_valid && !rx_stall && !res_valid |=> ##1 res_valid)
    else $error("result beat missing after two cycles");

endmodule

bind optical_flow_frame_parser ofp_checker u_ofp_checker (.*);

// File: dv/ofp_flow_checker.sv
// Scoreboard of the optical-flow frame parser: predicts every result beat and compares it.
`timescale 1ns / 1ps
module ofp_flow_checker import ofp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       rx_valid,
  input  logic       rx_stall,
  input  ofp_in_t    rx_item,
  input  logic       res_valid,
  input  logic       res_stall,
  input  ofp_out_t   res_item,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data,
  output int         fail_count,
  output int         open_beats
);

  typedef enum logic [1:0] {SEEK_SYNC, SEEK_ID, IN_BODY, PHASE_SPARE} phase_t;

  ofp_cfg_t           cfg;
  phase_t             phase;
  logic [3:0]         idx;
  logic [7:0]         store [0:15];
  logic [7:0]         fault_run;
  logic               valid_flag;
  logic signed [15:0] lat_x, lat_y, lat_h;
  logic [7:0]         lat_q;
  logic [31:0]        run_x, run_y, tot_x, tot_y;
  logic [15:0]        good_cnt;
  ofp_out_t           awaited [$];

  // Check tail and checksum of the collected frame; latch and accumulate when good.
  function automatic logic close_frame(input logic [7:0] tail);
    logic [7:0] ck;
    logic [3:0] ck_pos;
    logic [3:0] k;
    ck_pos = cfg.frame_format ? 4'd8 : 4'd6;
    ck = '0;
    for (k = FIRST_STORED; k < ck_pos; k++) ck = ck + store[k];
    if (tail != TAIL_BYTE || ck != store[ck_pos]) return 1'b0;
    good_cnt = good_cnt + 16'd1;
    lat_x = {store[3], store[2]};
    lat_y = {store[5], store[4]};
    lat_q = store[ck_pos + 4'd1];
    run_x = run_x + {{16{lat_x[15]}}, lat_x};
    run_y = run_y + {{16{lat_y[15]}}, lat_y};
    if (cfg.frame_format) begin
      lat_h = {store[7], store[6]};
      tot_x = tot_x + {{16{lat_x[15]}}, lat_x};
      tot_y = tot_y + {{16{lat_y[15]}}, lat_y};
    end
    if (lat_q < cfg.quality_threshold) begin
      // saturate at the limit and drop validity once it is passed
      if (fault_run >= cfg.fault_limit) begin
        fault_run  = cfg.fault_limit;
        valid_flag = 1'b0;
      end else begin
        fault_run = fault_run + 8'd1;
      end
    end else begin
      fault_run  = '0;
      valid_flag = 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic ofp_out_t step_parser(input ofp_in_t it);
    ofp_out_t r;
    logic     done;
    done = 1'b0;
    if (it.command == CMD_CLEAR) begin
      run_x = '0;
      run_y = '0;
    end else begin
      case (phase)
        SEEK_SYNC: begin
          if (it.rx_byte == HDR0_BYTE) begin
            store[0] = it.rx_byte;
            idx      = 4'd1;
            phase    = SEEK_ID;
          end else begin
            idx = '0;
          end
        end
        SEEK_ID: begin
          if (it.rx_byte == HDR1_BYTE) begin
            store[1] = it.rx_byte;
            idx      = 4'd2;
            phase    = IN_BODY;
          end else begin
            idx   = '0;
            phase = SEEK_SYNC;
          end
        end
        IN_BODY: begin
          store[idx] = it.rx_byte;
          if (idx >= (cfg.frame_format ? LAST_IDX_LONG : LAST_IDX_SHORT)) begin
            phase = SEEK_SYNC;
            idx   = '0;
            done  = close_frame(it.rx_byte);
          end else begin
            idx = idx + 4'd1;
          end
        end
        default: begin
          phase = SEEK_SYNC;
          idx   = '0;
        end
      endcase
    end
    r.frame_done  = done;
    r.flow_x      = lat_x;
    r.flow_y      = lat_y;
    r.quality     = lat_q;
    r.height      = lat_h;
    r.sum_x       = run_x;
    r.sum_y       = run_y;
    r.total_x     = tot_x;
    r.total_y     = tot_y;
    r.flow_valid  = valid_flag;
    r.frame_count = good_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    ofp_out_t want;
    if (rst) begin
      cfg.frame_format      = 1'b1;
      cfg.quality_threshold = QUALITY_THRESHOLD_RESET;
      cfg.fault_limit       = FAULT_LIMIT_RESET;
      phase      = SEEK_SYNC;
      idx        = '0;
      store      = '{default: '0};
      fault_run  = '0;
      valid_flag = 1'b0;
      lat_x      = '0;
      lat_y      = '0;
      lat_q      = '0;
      lat_h      = '0;
      run_x      = '0;
      run_y      = '0;
      tot_x      = '0;
      tot_y      = '0;
      good_cnt   = '0;
      awaited.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_FRAME_FORMAT:      cfg.frame_format      = cfg_data[0];
          REG_QUALITY_THRESHOLD: cfg.quality_threshold = cfg_data;
          REG_FAULT_LIMIT:       cfg.fault_limit       = cfg_data;
          default: ;
        endcase
      end
      if (rx_valid && !rx_stall) awaited.push_back(step_parser(rx_item));
      if (res_valid && !res_stall) begin
        if (awaited.size() == 0) begin
          $error("result beat with no prediction waiting");
          fail_count++;
        end else begin
          want = awaited.pop_front();
          check_field("frame_done", 32'(want.frame_done), 32'(res_item.frame_done));
          check_field("flow_x", 32'(want.flow_x), 32'(res_item.flow_x));
          check_field("flow_y", 32'(want.flow_y), 32'(res_item.flow_y));
          check_field("quality", 32'(want.quality), 32'(res_item.quality));
          check_field("height", 32'(want.height), 32'(res_item.height));
          check_field("sum_x", want.sum_x, res_item.sum_x);
          check_field("sum_y", want.sum_y, res_item.sum_y);
          check_field("total_x", want.total_x, res_item.total_x);
          check_field("total_y", want.total_y, res_item.total_y);
          check_field("flow_valid", 32'(want.flow_valid), 32'(res_item.flow_valid));
          check_field("frame_count", 32'(want.frame_count), 32'(res_item.frame_count));
        end
      end
    end
    open_beats = awaited.size();
  end

endmodule

// File: dv/tb_optical_flow_frame_parser.sv
// Testbench top of the optical-flow frame parser: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_optical_flow_frame_parser;
  import ofp_pkg::*;

  // Far above the slowest correct run.
  localparam int CYCLE_LIMIT  = 200000;
  // Extra idle wait at the end, after every predicted result beat has come back.
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {FLAW_NONE, FLAW_SUM, FLAW_TAIL} flaw_t;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       rx_valid  = 1'b0;
  logic       rx_stall;
  ofp_in_t    rx_item   = '0;
  logic       res_valid;
  logic       res_stall = 1'b0;
  ofp_out_t   res_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [1:0] cfg_index = REG_FRAME_FORMAT;
  logic [7:0] cfg_data  = '0;

  int         fail_count;
  int         open_beats;
  int         beats_sent = 0;
  int         cycles     = 0;
  // Set for the closing stretch: no gaps on the byte side, no stalls on the result side.
  logic       calm       = 1'b0;
  // Mirror of the registers, used to shape frames.
  logic       cur_fmt    = 1'b1;
  logic [7:0] cur_thr    = QUALITY_THRESHOLD_RESET;

  optical_flow_frame_parser uut (
    .clk       (clk),
    .rst       (rst),
    .rx_valid  (rx_valid),
    .rx_stall  (rx_stall),
    .rx_item   (rx_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ofp_flow_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .rx_valid   (rx_valid),
    .rx_stall   (rx_stall),
    .rx_item    (rx_item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res_item   (res_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .open_beats (open_beats)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog: give up on a hang or on results that never show.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Result side: stall in random bursts, with free stretches in between.
  initial begin
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 5) == 0) begin
        res_stall = 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        res_stall = 1'b0;
      end else if (!calm && $urandom_range(0, 29) == 0) begin
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end
    end
  end

  // Offer one beat and hold it until the block takes it; sometimes idle first.
  task automatic put_beat(input logic cmd, input logic [7:0] b);
    @(negedge clk);
    if (!calm && $urandom_range(0, 4) == 0) begin
      rx_valid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    rx_item.command = cmd;
    rx_item.rx_byte = b;
    rx_valid        = 1'b1;
    @(posedge clk);
    while (rx_stall) @(posedge clk);
    beats_sent++;
  endtask

  // Drop valid and wait until every predicted result beat has come back.
  task automatic settle();
    @(negedge clk);
    rx_valid = 1'b0;
    while (open_beats != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [7:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Write all three registers while idle; junk in the upper format bits must be ignored.
  task automatic set_mode(input logic fmt, input logic [7:0] thr, input logic [7:0] lim);
    logic [6:0] junk;
    junk = 7'($urandom);
    settle();
    write_reg(REG_FRAME_FORMAT, {junk, fmt});
    write_reg(REG_QUALITY_THRESHOLD, thr);
    write_reg(REG_FAULT_LIMIT, lim);
    cur_fmt = fmt;
    cur_thr = thr;
  endtask

  // Build a frame in the current format; spoil checksum or tail on request, and
  // now and then slip a clear command before or between its bytes.
  task automatic send_frame(input logic [15:0] fx, input logic [15:0] fy,
                            input logic [15:0] fh, input logic [7:0] q, input flaw_t flaw);
    logic [7:0] fb [$];
    logic [7:0] ck;
    logic [7:0] spoil;
    logic [7:0] tail;
    int         clr_at;
    fb.push_back(HDR0_BYTE);
    fb.push_back(HDR1_BYTE);
    fb.push_back(fx[7:0]);
    fb.push_back(fx[15:8]);
    fb.push_back(fy[7:0]);
    fb.push_back(fy[15:8]);
    if (cur_fmt) begin
      fb.push_back(fh[7:0]);
      fb.push_back(fh[15:8]);
    end
    ck = '0;
    for (int k = 2; k < fb.size(); k++) ck = ck + fb[k];
    spoil = 8'($urandom_range(1, 255));
    if (flaw == FLAW_SUM) ck = ck ^ spoil;
    tail = TAIL_BYTE;
    if (flaw == FLAW_TAIL) begin
      tail = 8'($urandom);
      if (tail == TAIL_BYTE) tail = 8'h00;
    end
    fb.push_back(ck);
    fb.push_back(q);
    fb.push_back(tail);
    clr_at = $urandom_range(0, 60);
    for (int k = 0; k < fb.size(); k++) begin
      if (k == clr_at) put_beat(CMD_CLEAR, 8'($urandom));
      put_beat(CMD_BYTE, fb[k]);
    end
  endtask

  function automatic logic [15:0] rand_flow();
    logic [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 11))
      0:       v = 16'h7FFF;
      1:       v = 16'h8000;
      2:       v = 16'hFFFF;
      3:       v = 16'h0000;
      default: ;
    endcase
    return v;
  endfunction

  // Aim quality on both sides of the current threshold, extremes included.
  function automatic logic [7:0] pick_quality();
    logic [7:0] q;
    case ($urandom_range(0, 9))
      0:          q = 8'h00;
      1:          q = 8'hFF;
      2, 3, 4:    q = (cur_thr == 0) ? 8'h00 : 8'($urandom_range(cur_thr - 1, 0));
      default:    q = 8'($urandom_range(255, cur_thr));
    endcase
    return q;
  endfunction

  // Mostly well-formed frames with random content; the rest broken frames,
  // false headers, loose bytes and clear commands.
  task automatic run_phase(input int budget);
    int         stop_at;
    int         pick;
    logic [7:0] b;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) begin
        send_frame(rand_flow(), rand_flow(), rand_flow(), pick_quality(), FLAW_NONE);
      end else if (pick < 74) begin
        send_frame(rand_flow(), rand_flow(), rand_flow(), pick_quality(), FLAW_SUM);
      end else if (pick < 81) begin
        send_frame(rand_flow(), rand_flow(), rand_flow(), pick_quality(), FLAW_TAIL);
      end else if (pick < 87) begin
        b = 8'($urandom);
        if (b == HDR1_BYTE) b = b ^ 8'h01;
        put_beat(CMD_BYTE, HDR0_BYTE);
        put_beat(CMD_BYTE, b);
      end else if (pick < 94) begin
        put_beat(CMD_BYTE, 8'($urandom));
      end else begin
        put_beat(CMD_CLEAR, 8'($urandom));
      end
    end
  endtask

  initial begin
    // Hold reset, release it between edges.
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Good long frame at the flow extremes, with top quality.
    send_frame(16'h8000, 16'h7FFF, 16'h8000, 8'hFF, FLAW_NONE);
    // Second header byte wrong: the repeated sync byte is not taken as a new start,
    // so the trailing id byte is ignored.
    put_beat(CMD_BYTE, HDR0_BYTE);
    put_beat(CMD_BYTE, HDR0_BYTE);
    put_beat(CMD_BYTE, HDR1_BYTE);
    put_beat(CMD_CLEAR, 8'hFF);
    // Switch from long to short format in the middle of a frame: the next byte
    // ends it as the tail and the fields come from the short layout.
    put_beat(CMD_BYTE, HDR0_BYTE);
    put_beat(CMD_BYTE, HDR1_BYTE);
    put_beat(CMD_BYTE, 8'h01);
    put_beat(CMD_BYTE, 8'h00);
    put_beat(CMD_BYTE, 8'hFF);
    put_beat(CMD_BYTE, 8'hFF);
    put_beat(CMD_BYTE, 8'hFF);
    put_beat(CMD_BYTE, 8'h00);
    put_beat(CMD_BYTE, 8'h55);
    put_beat(CMD_BYTE, 8'h33);
    settle();
    write_reg(REG_FRAME_FORMAT, 8'h00);
    cur_fmt = 1'b0;
    put_beat(CMD_BYTE, TAIL_BYTE);

    // Random phases over a spread of settings, extremes among them.
    set_mode(1'b0, 8'd255, 8'd0);
    run_phase(90);
    set_mode(1'b1, 8'd128, 8'd3);
    run_phase(90);
    set_mode(1'b0, 8'd0, 8'd255);
    run_phase(90);
    set_mode(1'b1, 8'd90, 8'd255);
    run_phase(90);
    // Closing stretch at the reset settings with both sides at full rate.
    calm = 1'b1;
    set_mode(1'b1, QUALITY_THRESHOLD_RESET, FAULT_LIMIT_RESET);
    run_phase(90);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
